[rtl/gom_pkg.sv]
package gom_pkg;

  localparam int CFG_W       = 13;
  localparam int CFG_IDX_W   = 2;
  localparam int COORD_BITS  = 13;
  localparam int OP_W        = 2;
  localparam int DIR_W       = 2;
  localparam int DIV_W       = 14;
  localparam int CELL_W      = 16;
  localparam int IDX_W       = 27;
  localparam int PIX_W       = 12;
  localparam int MEM_ADDR_W  = 16;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 32;

  localparam int MAX_CELLS_DEF = 4096;

  localparam logic [CFG_IDX_W-1:0] CFG_AREA_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AREA_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE   = 2'd2;

  localparam logic [CFG_W-1:0] AREA_WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] AREA_HEIGHT_RST = 13'd480;
  localparam logic [CFG_W-1:0] CELL_SIZE_RST   = 13'd30;

  localparam logic [OP_W-1:0] OP_FILL     = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY    = 2'd1;
  localparam logic [OP_W-1:0] OP_NEIGHBOR = 2'd2;

  localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd3;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [CFG_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic                  rd_en;
    logic                  wr_en;
    logic [MEM_ADDR_W-1:0] addr;
    logic                  wdata;
  } mem_req_t;

endpackage

[rtl/gom_div.sv]
module gom_div (
  input  logic               clk,
  input  logic               rst_n,
  input  gom_pkg::div_req_t  req,
  output gom_pkg::div_rsp_t  rsp
);

  localparam int CNT_W = $clog2(gom_pkg::DIV_W);

  logic                      busy_r;
  logic                      done_r;
  logic [CNT_W-1:0]          cnt_r;
  logic [gom_pkg::DIV_W-1:0] quot_r;
  logic [gom_pkg::CFG_W-1:0] rem_r;
  logic [gom_pkg::CFG_W-1:0] dvs_r;

  logic [gom_pkg::DIV_W-1:0] trial;
  logic [gom_pkg::DIV_W-1:0] diff;
  logic                      take;

  always_comb begin
    trial = {rem_r, quot_r[gom_pkg::DIV_W-1]};
    diff  = trial - gom_pkg::DIV_W'(dvs_r);
    take  = (trial >= gom_pkg::DIV_W'(dvs_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r) begin
        if (req.start) begin
          busy_r <= 1'b1;
          cnt_r  <= CNT_W'(gom_pkg::DIV_W - 1);
          quot_r <= req.dividend;
          rem_r  <= '0;
          dvs_r  <= req.divisor;
        end
      end else begin
        quot_r <= {quot_r[gom_pkg::DIV_W-2:0], take};
        rem_r  <= take ? diff[gom_pkg::CFG_W-1:0] : trial[gom_pkg::CFG_W-1:0];
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - CNT_W'(1);
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

[rtl/gom_mem.sv]
module gom_mem #(
  parameter int MAX_CELLS = gom_pkg::MAX_CELLS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  gom_pkg::mem_req_t req,
  output logic              rdata,
  output logic              clr_busy
);

  localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

  logic          mem [MAX_CELLS];
  logic          clr_busy_r;
  logic [AW-1:0] clr_cnt_r;
  logic          rdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      if (clr_cnt_r == AW'(MAX_CELLS - 1)) begin
        clr_busy_r <= 1'b0;
      end else begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_cnt_r] <= 1'b0;
    end else if (req.wr_en) begin
      mem[req.addr[AW-1:0]] <= req.wdata;
    end
    if (req.rd_en) begin
      rdata_r <= mem[req.addr[AW-1:0]];
    end
  end

  assign rdata    = rdata_r;
  assign clr_busy = clr_busy_r;

endmodule

[rtl/grid_occupancy_map.sv]
// One-bit fill map over a uniform grid of square cells covering a pixel area. Each input
// word is a fill of a rectangle, a query of the cell under a position, or a query of its
// neighbor, and gives exactly one result word. All cell arithmetic runs through one shared
// restoring divider of 14 bits and one multiplier under a sequencer that takes one word
// at a time. A query runs four divisions and a fill six, after which the fill walks its
// covered cells row by row, reading each cell and writing it where its value differs; an
// empty fill or an unused op goes straight to the result. After reset the map is cleared
// one cell per cycle while in_tready stays low. A finished result waits in the output
// register while the next word is already being worked on. The user must write
// configuration only while the block is idle; the block itself does not enforce this.
module grid_occupancy_map #(
  parameter int MAX_CELLS = gom_pkg::MAX_CELLS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // pos_x, pos_y, rect_width, rect_height, fill_value, direction, zero fill
  input  logic [gom_pkg::IN_TDATA_W-1:0]   in_tdata,
  // op
  input  logic [gom_pkg::OP_W-1:0]         in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // found, cell_x_px, cell_y_px, cell_filled, repeat_seen, zero fill
  output logic [gom_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                             cfg_wr_en,
  input  logic [gom_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gom_pkg::CFG_W-1:0]        cfg_data
);

  localparam int CB  = gom_pkg::COORD_BITS;
  localparam int CW  = gom_pkg::CFG_W;
  localparam int DW  = gom_pkg::DIV_W;
  localparam int SW  = gom_pkg::CELL_W;
  localparam int IW  = gom_pkg::IDX_W;
  localparam int PW  = gom_pkg::PIX_W;
  localparam int PY_LSB  = CB;
  localparam int W_LSB   = 2 * CB;
  localparam int H_LSB   = W_LSB + CW;
  localparam int VAL_BIT = H_LSB + CW;
  localparam int DIR_LSB = VAL_BIT + 1;

  localparam logic [2:0] DK_COLS = 3'd0;
  localparam logic [2:0] DK_ROWS = 3'd1;
  localparam logic [2:0] DK_X    = 3'd2;
  localparam logic [2:0] DK_Y    = 3'd3;
  localparam logic [2:0] DK_W    = 3'd4;
  localparam logic [2:0] DK_H    = 3'd5;

  localparam logic signed [SW-1:0] ONE_S  = SW'(1);
  localparam logic signed [SW-1:0] ZERO_S = '0;

  typedef enum logic [3:0] {
    S_IDLE, S_DSTART, S_DWAIT, S_QADJ, S_QIDX, S_QADD, S_QCHK, S_QFIN,
    S_FSETUP, S_FBASE, S_FMUL, S_FROW, S_FCELL, S_FWR, S_OUT
  } state_t;

  state_t state_r;

  logic [CW-1:0] area_w_r, area_h_r, cell_size_r;

  logic [gom_pkg::OP_W-1:0]  op_r;
  logic [gom_pkg::DIR_W-1:0] dir_r;
  logic signed [CB-1:0]      px_r, py_r;
  logic [CW-1:0]             rw_r, rh_r;
  logic                      val_r;
  logic [CW-1:0]             cs_r;
  logic [2:0]                div_k_r;
  logic [CW-1:0]             cols_r, rows_r;
  logic signed [SW-1:0]      col_r, row_r;
  logic [DW-1:0]             nw_r, nh_r;
  logic signed [SW-1:0]      fc0_r, fc1_r, fr_r, fr1_r, fc_r;
  logic [IW-1:0]             base_r, idx_r, mul_r;
  logic                      in_grid_r;
  logic                      res_found_r, res_filled_r, res_rep_r;
  logic [PW-1:0]             res_x_r, res_y_r;
  logic                      out_valid_r, out_found_r, out_filled_r, out_rep_r;
  logic [PW-1:0]             out_x_r, out_y_r;

  gom_pkg::div_req_t div_req;
  gom_pkg::div_rsp_t div_rsp;
  gom_pkg::mem_req_t mem_req;
  logic              mem_rdata;
  logic              mem_busy;

  logic signed [DW-1:0] px_ext, py_ext;
  logic [DW-1:0]        dvd_x, dvd_y;
  logic                 q_neg;
  logic signed [SW-1:0] q_s;
  logic signed [SW-1:0] cols_s, rows_s, cols_m1, rows_m1;
  logic signed [SW-1:0] c1, r1;
  logic [DW-1:0]        mul_a;
  logic [CW-1:0]        mul_b;
  logic [2:0]           div_last;

  gom_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  gom_mem #(
    .MAX_CELLS (MAX_CELLS)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (mem_req),
    .rdata    (mem_rdata),
    .clr_busy (mem_busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_w_r    <= gom_pkg::AREA_WIDTH_RST;
      area_h_r    <= gom_pkg::AREA_HEIGHT_RST;
      cell_size_r <= gom_pkg::CELL_SIZE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        gom_pkg::CFG_AREA_WIDTH:  area_w_r    <= cfg_data;
        gom_pkg::CFG_AREA_HEIGHT: area_h_r    <= cfg_data;
        gom_pkg::CFG_CELL_SIZE:   cell_size_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    px_ext  = DW'(px_r);
    py_ext  = DW'(py_r);
    dvd_x   = px_r[CB-1] ? DW'($unsigned(-px_ext)) + DW'(cs_r) - DW'(1) : DW'($unsigned(px_r));
    dvd_y   = py_r[CB-1] ? DW'($unsigned(-py_ext)) + DW'(cs_r) - DW'(1) : DW'($unsigned(py_r));
    q_neg   = (div_k_r == DK_X) ? px_r[CB-1] : py_r[CB-1];
    q_s     = q_neg ? -$signed(SW'(div_rsp.quot)) : $signed(SW'(div_rsp.quot));
    cols_s  = $signed(SW'(cols_r));
    rows_s  = $signed(SW'(rows_r));
    cols_m1 = cols_s - ONE_S;
    rows_m1 = rows_s - ONE_S;
    c1      = col_r + $signed(SW'(nw_r)) - ONE_S;
    r1      = row_r + $signed(SW'(nh_r)) - ONE_S;
    div_last = (op_r == gom_pkg::OP_FILL) ? DK_H : DK_Y;

    div_req.start   = (state_r == S_DSTART);
    div_req.divisor = cs_r;
    case (div_k_r)
      DK_COLS: div_req.dividend = DW'(area_w_r);
      DK_ROWS: div_req.dividend = DW'(area_h_r);
      DK_X:    div_req.dividend = dvd_x;
      DK_Y:    div_req.dividend = dvd_y;
      DK_W:    div_req.dividend = DW'(rw_r) + DW'(cs_r) - DW'(1);
      DK_H:    div_req.dividend = DW'(rh_r) + DW'(cs_r) - DW'(1);
      default: div_req.dividend = '0;
    endcase

    case (state_r)
      S_QIDX:  begin mul_a = row_r[DW-1:0]; mul_b = cols_r; end
      S_QADD:  begin mul_a = col_r[DW-1:0]; mul_b = cs_r;   end
      S_QCHK:  begin mul_a = row_r[DW-1:0]; mul_b = cs_r;   end
      default: begin mul_a = fr_r[DW-1:0];  mul_b = cols_r; end
    endcase

    mem_req.rd_en = (state_r == S_QCHK) || (state_r == S_FCELL);
    mem_req.wr_en = (state_r == S_FWR) && (mem_rdata != val_r);
    mem_req.addr  = idx_r[gom_pkg::MEM_ADDR_W-1:0];
    mem_req.wdata = val_r;

    in_tready = (state_r == S_IDLE) && !mem_busy;
  end

  always_ff @(posedge clk) begin
    mul_r <= IW'(mul_a) * IW'(mul_b);
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_tready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            op_r  <= in_tuser;
            px_r  <= $signed(in_tdata[CB-1:0]);
            py_r  <= $signed(in_tdata[PY_LSB +: CB]);
            rw_r  <= in_tdata[W_LSB +: CW];
            rh_r  <= in_tdata[H_LSB +: CW];
            val_r <= in_tdata[VAL_BIT];
            dir_r <= in_tdata[DIR_LSB +: gom_pkg::DIR_W];
            cs_r  <= (cell_size_r == '0) ? CW'(1) : cell_size_r;
            div_k_r      <= DK_COLS;
            res_found_r  <= 1'b0;
            res_filled_r <= 1'b0;
            res_rep_r    <= 1'b0;
            res_x_r      <= '0;
            res_y_r      <= '0;
            case (in_tuser)
              gom_pkg::OP_FILL: begin
                if ((in_tdata[W_LSB +: CW] == '0) || (in_tdata[H_LSB +: CW] == '0)) begin
                  state_r <= S_OUT;
                end else begin
                  state_r <= S_DSTART;
                end
              end
              gom_pkg::OP_QUERY:    state_r <= S_DSTART;
              gom_pkg::OP_NEIGHBOR: state_r <= S_DSTART;
              default:              state_r <= S_OUT;
            endcase
          end
        end
        S_DSTART: state_r <= S_DWAIT;
        S_DWAIT: begin
          if (div_rsp.done) begin
            case (div_k_r)
              DK_COLS: cols_r <= div_rsp.quot[CW-1:0];
              DK_ROWS: rows_r <= div_rsp.quot[CW-1:0];
              DK_X:    col_r  <= q_s;
              DK_Y:    row_r  <= q_s;
              DK_W:    nw_r   <= div_rsp.quot;
              DK_H:    nh_r   <= div_rsp.quot;
              default: ;
            endcase
            if (div_k_r == div_last) begin
              state_r <= (op_r == gom_pkg::OP_FILL) ? S_FSETUP : S_QADJ;
            end else begin
              div_k_r <= div_k_r + 3'd1;
              state_r <= S_DSTART;
            end
          end
        end
        S_QADJ: begin
          if (op_r == gom_pkg::OP_NEIGHBOR) begin
            case (dir_r)
              gom_pkg::DIR_UP:    row_r <= row_r - ONE_S;
              gom_pkg::DIR_DOWN:  row_r <= row_r + ONE_S;
              gom_pkg::DIR_LEFT:  col_r <= col_r - ONE_S;
              gom_pkg::DIR_RIGHT: col_r <= col_r + ONE_S;
              default: ;
            endcase
          end
          state_r <= S_QIDX;
        end
        S_QIDX: begin
          in_grid_r <= !col_r[SW-1] && !row_r[SW-1] && (col_r < cols_s) && (row_r < rows_s);
          state_r   <= S_QADD;
        end
        S_QADD: begin
          idx_r   <= mul_r + IW'($unsigned(col_r));
          state_r <= S_QCHK;
        end
        S_QCHK: begin
          res_found_r <= in_grid_r && (idx_r < IW'(MAX_CELLS));
          res_x_r     <= mul_r[PW-1:0];
          state_r     <= S_QFIN;
        end
        S_QFIN: begin
          if (res_found_r) begin
            res_y_r      <= mul_r[PW-1:0];
            res_filled_r <= mem_rdata;
          end else begin
            res_x_r <= '0;
          end
          state_r <= S_OUT;
        end
        S_FSETUP: begin
          fc0_r   <= col_r[SW-1] ? ZERO_S : col_r;
          fr_r    <= row_r[SW-1] ? ZERO_S : row_r;
          fc1_r   <= (c1 > cols_m1) ? cols_m1 : c1;
          fr1_r   <= (r1 > rows_m1) ? rows_m1 : r1;
          state_r <= S_FBASE;
        end
        S_FBASE: begin
          if ((fc0_r > fc1_r) || (fr_r > fr1_r)) begin
            state_r <= S_OUT;
          end else begin
            state_r <= S_FMUL;
          end
        end
        S_FMUL: begin
          base_r  <= mul_r;
          state_r <= S_FROW;
        end
        S_FROW: begin
          if (fr_r > fr1_r) begin
            state_r <= S_OUT;
          end else begin
            idx_r   <= base_r + IW'($unsigned(fc0_r));
            fc_r    <= fc0_r;
            state_r <= S_FCELL;
          end
        end
        S_FCELL: begin
          if (fc_r > fc1_r) begin
            fr_r    <= fr_r + ONE_S;
            base_r  <= base_r + IW'(cols_r);
            state_r <= S_FROW;
          end else if (idx_r >= IW'(MAX_CELLS)) begin
            state_r <= S_OUT;
          end else begin
            state_r <= S_FWR;
          end
        end
        S_FWR: begin
          res_found_r <= 1'b1;
          if (mem_rdata == val_r) begin
            res_rep_r <= 1'b1;
          end
          fc_r    <= fc_r + ONE_S;
          idx_r   <= idx_r + IW'(1);
          state_r <= S_FCELL;
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r  <= 1'b1;
            out_found_r  <= res_found_r;
            out_x_r      <= res_x_r;
            out_y_r      <= res_y_r;
            out_filled_r <= res_filled_r;
            out_rep_r    <= res_rep_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_rep_r, out_filled_r, out_y_r, out_x_r, out_found_r};

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    mem_busy |-> !in_tready)
    else $error("Input word accepted during the clearing pass.");

  a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DWAIT))
    else $error("Divider finished while the sequencer was not waiting for it.");

  a_write_only_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.wr_en |-> (state_r == S_FWR) && !mem_busy)
    else $error("Map written outside the fill walk.");

  a_result_not_overwritten: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) && out_valid_r && !out_tready |=> (state_r == S_OUT))
    else $error("Result register reloaded while its word was still waiting.");

endmodule

[test/grid_occupancy_map_tb.sv]
module grid_occupancy_map_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAP_CELLS = gom_pkg::MAX_CELLS_DEF;
  localparam int CW        = gom_pkg::CFG_W;
  localparam int PW        = gom_pkg::PIX_W;
  localparam logic [gom_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [gom_pkg::OP_W-1:0]  op;
    logic signed [12:0]        pos_x;
    logic signed [12:0]        pos_y;
    logic [12:0]               rect_w;
    logic [12:0]               rect_h;
    logic                      fill_val;
    logic [gom_pkg::DIR_W-1:0] dir;
  } map_word_t;

  typedef struct {
    logic          found;
    logic [PW-1:0] cell_x;
    logic [PW-1:0] cell_y;
    logic          cell_filled;
    logic          repeat_seen;
  } cell_report_t;

  logic                            clk;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [gom_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic [gom_pkg::OP_W-1:0]        in_tuser = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [gom_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            cfg_wr_en = 1'b0;
  logic [gom_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CW-1:0]                   cfg_data = '0;

  // Mirror of the block's registers and fill map.
  logic [CW-1:0] grid_w_px = gom_pkg::AREA_WIDTH_RST;
  logic [CW-1:0] grid_h_px = gom_pkg::AREA_HEIGHT_RST;
  logic [CW-1:0] cell_px   = gom_pkg::CELL_SIZE_RST;
  bit            fill_map [0:MAP_CELLS-1];

  map_word_t    pending_words[$];
  map_word_t    offered_word;
  cell_report_t expected_cells[$];
  int           words_queued = 0;
  int           results_seen = 0;
  int           fail_count = 0;
  bit           no_idle = 1'b0;

  grid_occupancy_map u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #1_000_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int div_floor(int a, int b);
    int q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  function automatic cell_report_t apply_map_op(map_word_t it);
    cell_report_t r;
    int cs, cols, rows, c0, c1, r0, r1, col, row, idx, snap;
    r = '{default: '0};
    cs = (cell_px == 0) ? 1 : int'(cell_px);
    cols = int'(grid_w_px) / cs;
    rows = int'(grid_h_px) / cs;
    case (it.op)
      gom_pkg::OP_FILL: begin
        if (it.rect_w != 0 && it.rect_h != 0) begin
          c0 = div_floor(int'(it.pos_x), cs);
          c1 = c0 + (int'(it.rect_w) + cs - 1) / cs - 1;
          r0 = div_floor(int'(it.pos_y), cs);
          r1 = r0 + (int'(it.rect_h) + cs - 1) / cs - 1;
          if (c0 < 0) c0 = 0;
          if (r0 < 0) r0 = 0;
          if (c1 > cols - 1) c1 = cols - 1;
          if (r1 > rows - 1) r1 = rows - 1;
          for (row = r0; row <= r1; row++) begin
            if (row * cols + c0 >= MAP_CELLS) break;
            for (col = c0; col <= c1; col++) begin
              idx = row * cols + col;
              if (idx >= MAP_CELLS) break;
              r.found = 1'b1;
              if (fill_map[idx] == it.fill_val) r.repeat_seen = 1'b1;
              else fill_map[idx] = it.fill_val;
            end
          end
        end
      end
      gom_pkg::OP_QUERY, gom_pkg::OP_NEIGHBOR: begin
        col = div_floor(int'(it.pos_x), cs);
        row = div_floor(int'(it.pos_y), cs);
        if (it.op == gom_pkg::OP_NEIGHBOR) begin
          case (it.dir)
            gom_pkg::DIR_UP:   row = row - 1;
            gom_pkg::DIR_DOWN: row = row + 1;
            gom_pkg::DIR_LEFT: col = col - 1;
            default:           col = col + 1;
          endcase
        end
        if (col >= 0 && row >= 0 && col < cols && row < rows) begin
          idx = row * cols + col;
          if (idx < MAP_CELLS) begin
            r.found = 1'b1;
            snap = col * cs;
            r.cell_x = snap[PW-1:0];
            snap = row * cs;
            r.cell_y = snap[PW-1:0];
            r.cell_filled = fill_map[idx];
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) expected_cells.push_back(apply_map_op(offered_word));
      if (!in_tvalid || in_tready) begin
        if (pending_words.size() != 0 && (no_idle || $urandom_range(0, 99) >= 26)) begin
          offered_word = pending_words.pop_front();
          in_tdata <= {1'b0, offered_word.dir, offered_word.fill_val, offered_word.rect_h,
                       offered_word.rect_w, offered_word.pos_y, offered_word.pos_x};
          in_tuser <= offered_word.op;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    cell_report_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_cells.size() == 0) begin
          $error("result word 0x%08h arrived with no expectation pending", out_tdata);
          fail_count++;
        end else begin
          want = expected_cells.pop_front();
          if (out_tdata[0] !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, out_tdata[0]);
            fail_count++;
          end
          if (out_tdata[12:1] !== want.cell_x) begin
            $error("cell_x_px: expected %0d, got %0d", want.cell_x, out_tdata[12:1]);
            fail_count++;
          end
          if (out_tdata[24:13] !== want.cell_y) begin
            $error("cell_y_px: expected %0d, got %0d", want.cell_y, out_tdata[24:13]);
            fail_count++;
          end
          if (out_tdata[25] !== want.cell_filled) begin
            $error("cell_filled: expected %0d, got %0d", want.cell_filled, out_tdata[25]);
            fail_count++;
          end
          if (out_tdata[26] !== want.repeat_seen) begin
            $error("repeat_seen: expected %0d, got %0d", want.repeat_seen, out_tdata[26]);
            fail_count++;
          end
        end
      end
      out_tready <= no_idle || ($urandom_range(0, 99) >= 26);
    end
  end

  function automatic map_word_t mk_word(logic [gom_pkg::OP_W-1:0] op, int x, int y,
                                        int w, int h, logic v,
                                        logic [gom_pkg::DIR_W-1:0] d);
    map_word_t it;
    it.op = op;
    it.pos_x = 13'(x);
    it.pos_y = 13'(y);
    it.rect_w = 13'(w);
    it.rect_h = 13'(h);
    it.fill_val = v;
    it.dir = d;
    return it;
  endfunction

  function automatic logic signed [12:0] random_coord(int span_px, int cs);
    int v, hi;
    if ($urandom_range(0, 99) < 25) return 13'($urandom);
    hi = (span_px + 2 * cs > 8191) ? 8191 : span_px + 2 * cs;
    v = int'($urandom_range(0, hi));
    v = v - cs;
    if (v > 4095) v = 4095;
    if (v < -4096) v = -4096;
    return 13'(v);
  endfunction

  function automatic logic [12:0] random_extent(int cs);
    int pick, hi;
    pick = int'($urandom_range(0, 99));
    if (pick < 10) return 13'($urandom_range(0, 8191));
    if (pick < 15) return 13'd0;
    hi = (4 * cs > 8191) ? 8191 : 4 * cs;
    return 13'($urandom_range(1, hi));
  endfunction

  function automatic map_word_t random_word();
    map_word_t it;
    int cs, pick;
    cs = (cell_px == 0) ? 1 : int'(cell_px);
    pick = int'($urandom_range(0, 99));
    it.op = (pick < 40) ? gom_pkg::OP_FILL : (pick < 70) ? gom_pkg::OP_QUERY :
            (pick < 95) ? gom_pkg::OP_NEIGHBOR : OP_UNUSED;
    it.pos_x = random_coord(int'(grid_w_px), cs);
    it.pos_y = random_coord(int'(grid_h_px), cs);
    it.rect_w = random_extent(cs);
    it.rect_h = random_extent(cs);
    it.fill_val = 1'($urandom_range(0, 1));
    it.dir = 2'($urandom_range(0, 3));
    return it;
  endfunction

  task automatic queue_word(map_word_t it);
    pending_words.push_back(it);
    words_queued++;
  endtask

  task automatic wait_drained();
    while (results_seen < words_queued) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [gom_pkg::CFG_IDX_W-1:0] idx, logic [CW-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_grid(int w, int h, int cs, int count);
    wait_drained();
    write_reg(gom_pkg::CFG_AREA_WIDTH, CW'(w));
    write_reg(gom_pkg::CFG_AREA_HEIGHT, CW'(h));
    write_reg(gom_pkg::CFG_CELL_SIZE, CW'(cs));
    grid_w_px = CW'(w);
    grid_h_px = CW'(h);
    cell_px = CW'(cs);
    repeat (count) queue_word(random_word());
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset grid: 21 columns by 16 rows of 30 pixel cells.
    queue_word(mk_word(gom_pkg::OP_QUERY, 0, 0, 0, 0, 1'b0, gom_pkg::DIR_UP));
    queue_word(mk_word(gom_pkg::OP_FILL, 0, 0, 30, 30, 1'b1, gom_pkg::DIR_UP));
    queue_word(mk_word(gom_pkg::OP_FILL, 0, 0, 30, 30, 1'b1, gom_pkg::DIR_UP));
    queue_word(mk_word(gom_pkg::OP_QUERY, 29, 29, 0, 0, 1'b0, gom_pkg::DIR_UP));
    queue_word(mk_word(gom_pkg::OP_NEIGHBOR, 0, 0, 0, 0, 1'b0, gom_pkg::DIR_UP));
    queue_word(mk_word(gom_pkg::OP_NEIGHBOR, 0, 0, 0, 0, 1'b0, gom_pkg::DIR_LEFT));
    queue_word(mk_word(gom_pkg::OP_NEIGHBOR, 0, 0, 0, 0, 1'b0, gom_pkg::DIR_RIGHT));
    queue_word(mk_word(gom_pkg::OP_NEIGHBOR, 0, 0, 0, 0, 1'b0, gom_pkg::DIR_DOWN));
    queue_word(mk_word(gom_pkg::OP_QUERY, -1, 0, 0, 0, 1'b0, gom_pkg::DIR_UP));
    queue_word(mk_word(gom_pkg::OP_QUERY, 630, 0, 0, 0, 1'b0, gom_pkg::DIR_UP));
    queue_word(mk_word(gom_pkg::OP_QUERY, 629, 479, 0, 0, 1'b0, gom_pkg::DIR_UP));
    queue_word(mk_word(gom_pkg::OP_FILL, 30, 30, 0, 60, 1'b1, gom_pkg::DIR_UP));
    queue_word(mk_word(gom_pkg::OP_FILL, 30, 30, 60, 0, 1'b1, gom_pkg::DIR_UP));
    queue_word(mk_word(gom_pkg::OP_FILL, -4096, -4096, 8191, 8191, 1'b1,
                       gom_pkg::DIR_RIGHT));
    queue_word(mk_word(gom_pkg::OP_FILL, -4096, -4096, 8191, 8191, 1'b0,
                       gom_pkg::DIR_RIGHT));
    queue_word(mk_word(gom_pkg::OP_QUERY, 4095, 4095, 0, 0, 1'b1, gom_pkg::DIR_UP));
    queue_word(mk_word(gom_pkg::OP_NEIGHBOR, -4096, -4096, 0, 0, 1'b0,
                       gom_pkg::DIR_RIGHT));
    queue_word(mk_word(gom_pkg::OP_NEIGHBOR, -1, 0, 0, 0, 1'b0, gom_pkg::DIR_RIGHT));
    queue_word(mk_word(gom_pkg::OP_NEIGHBOR, 630, 0, 0, 0, 1'b0, gom_pkg::DIR_LEFT));
    queue_word(mk_word(OP_UNUSED, -1, -1, 8191, 8191, 1'b1, gom_pkg::DIR_RIGHT));
    queue_word(mk_word(gom_pkg::OP_FILL, 600, 450, 100, 100, 1'b1, gom_pkg::DIR_UP));
    queue_word(mk_word(gom_pkg::OP_QUERY, 4095, -1, 0, 0, 1'b0, gom_pkg::DIR_UP));
    queue_word(mk_word(gom_pkg::OP_NEIGHBOR, 629, 479, 0, 0, 1'b0, gom_pkg::DIR_DOWN));
    repeat (350) queue_word(random_word());

    no_idle = 1'b1;
    run_grid(4096, 4096, 64, 250);
    wait_drained();
    no_idle = 1'b0;
    run_grid(40, 30, 0, 200);
    run_grid(8191, 4096, 4096, 150);
    run_grid(10, 200, 50, 80);
    run_grid(8191, 8191, 2000, 200);
    run_grid(8191, 8191, 1, 200);
    run_grid(1, 1, 1, 100);
    run_grid(int'(gom_pkg::AREA_WIDTH_RST), int'(gom_pkg::AREA_HEIGHT_RST),
             int'(gom_pkg::CELL_SIZE_RST), 200);
    wait_drained();
    repeat (200) @(posedge clk);

    if (expected_cells.size() != 0) begin
      $error("%0d expected result words never arrived", expected_cells.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
